### rtl/segment_intersection_point_defines.svh
// Assertion macros used by the segment intersection top level.
`ifndef SEGMENT_INTERSECTION_POINT_DEFINES_SVH
`define SEGMENT_INTERSECTION_POINT_DEFINES_SVH

// Same-cycle implication, checked on aclk outside reset.
`define SIP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("segment intersection check failed");

// Next-cycle implication, checked on aclk outside reset.
`define SIP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("segment intersection check failed");

`endif

### rtl/sip_pkg.sv
// Shared types for the segment intersection pipeline.
package sip_pkg;

    typedef enum logic [1:0] {
        ORIENT_COLLINEAR = 2'd0,
        ORIENT_POS       = 2'd1,
        ORIENT_NEG       = 2'd2
    } orient_t;

    // Control bits that ride along with each word through the pipeline.
    typedef struct packed {
        logic valid;
        logic hit;
        logic par;
        logic neg_x;
        logic neg_y;
    } pipe_ctl_t;

endpackage

### rtl/sip_front.sv
// Front end: differences, products, orientation test and divider operands.
module sip_front
    import sip_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [8*COORD_BITS-1:0]   in_data,
    output pipe_ctl_t                 ctl,
    output logic [2*COORD_BITS+2:0]   dd,
    output logic [2*COORD_BITS+2:0]   num,
    output logic [COORD_BITS:0]       mag_x,
    output logic [COORD_BITS:0]       mag_y,
    output logic signed [COORD_BITS-1:0] p1x_o,
    output logic signed [COORD_BITS-1:0] p1y_o
);
    localparam int C  = COORD_BITS;
    localparam int W1 = C + 1;
    localparam int WP = 2 * C + 2;
    localparam int WD = 2 * C + 3;

    function automatic logic within_box(input logic signed [C-1:0] px, py, qx, qy, rx, ry);
        logic signed [C-1:0] xlo, xhi, ylo, yhi;
        xlo = (px < rx) ? px : rx;
        xhi = (px < rx) ? rx : px;
        ylo = (py < ry) ? py : ry;
        yhi = (py < ry) ? ry : py;
        return (qx >= xlo) && (qx <= xhi) && (qy >= ylo) && (qy <= yhi);
    endfunction

    function automatic orient_t orient_of(input logic signed [WD-1:0] v);
        if (v == '0) begin
            return ORIENT_COLLINEAR;
        end
        return v[WD-1] ? ORIENT_NEG : ORIENT_POS;
    endfunction

    logic signed [C-1:0] p1x, p1y, q1x, q1y, p2x, p2y, q2x, q2y;
    assign p1x = in_data[0*C +: C];
    assign p1y = in_data[1*C +: C];
    assign q1x = in_data[2*C +: C];
    assign q1y = in_data[3*C +: C];
    assign p2x = in_data[4*C +: C];
    assign p2y = in_data[5*C +: C];
    assign q2x = in_data[6*C +: C];
    assign q2y = in_data[7*C +: C];

    // Stage 1: coordinate differences.
    logic                 v1_reg;
    logic signed [C-1:0]  c1_reg [8];
    logic signed [W1-1:0] dax_reg, day_reg, dbx_reg, dby_reg;
    logic signed [W1-1:0] e1x_reg, e1y_reg, e2x_reg, e2y_reg;
    logic signed [W1-1:0] e3x_reg, e3y_reg, e4x_reg, e4y_reg, sx_reg, sy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_reg[0] <= p1x; c1_reg[1] <= p1y; c1_reg[2] <= q1x; c1_reg[3] <= q1y;
            c1_reg[4] <= p2x; c1_reg[5] <= p2y; c1_reg[6] <= q2x; c1_reg[7] <= q2y;
            dax_reg <= {q1x[C-1], q1x} - {p1x[C-1], p1x};
            day_reg <= {q1y[C-1], q1y} - {p1y[C-1], p1y};
            dbx_reg <= {q2x[C-1], q2x} - {p2x[C-1], p2x};
            dby_reg <= {q2y[C-1], q2y} - {p2y[C-1], p2y};
            e1x_reg <= {p2x[C-1], p2x} - {q1x[C-1], q1x};
            e1y_reg <= {p2y[C-1], p2y} - {q1y[C-1], q1y};
            e2x_reg <= {q2x[C-1], q2x} - {q1x[C-1], q1x};
            e2y_reg <= {q2y[C-1], q2y} - {q1y[C-1], q1y};
            e3x_reg <= {p1x[C-1], p1x} - {q2x[C-1], q2x};
            e3y_reg <= {p1y[C-1], p1y} - {q2y[C-1], q2y};
            e4x_reg <= {q1x[C-1], q1x} - {q2x[C-1], q2x};
            e4y_reg <= {q1y[C-1], q1y} - {q2y[C-1], q2y};
            sx_reg  <= {p1x[C-1], p1x} - {p2x[C-1], p2x};
            sy_reg  <= {p1y[C-1], p1y} - {p2y[C-1], p2y};
        end
    end

    // Stage 2: the twelve products and the bounding-box tests.
    logic                 v2_reg;
    logic signed [WP-1:0] pr_reg [12];
    logic [3:0]           box_reg;
    logic signed [W1-1:0] dax2_reg, day2_reg;
    logic signed [C-1:0]  p1x2_reg, p1y2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pr_reg[0]  <= day_reg * e1x_reg;
            pr_reg[1]  <= dax_reg * e1y_reg;
            pr_reg[2]  <= day_reg * e2x_reg;
            pr_reg[3]  <= dax_reg * e2y_reg;
            pr_reg[4]  <= dby_reg * e3x_reg;
            pr_reg[5]  <= dbx_reg * e3y_reg;
            pr_reg[6]  <= dby_reg * e4x_reg;
            pr_reg[7]  <= dbx_reg * e4y_reg;
            pr_reg[8]  <= dax_reg * dby_reg;
            pr_reg[9]  <= dbx_reg * day_reg;
            pr_reg[10] <= dbx_reg * sy_reg;
            pr_reg[11] <= dby_reg * sx_reg;
            box_reg[0] <= within_box(c1_reg[0], c1_reg[1], c1_reg[4], c1_reg[5],
                                     c1_reg[2], c1_reg[3]);
            box_reg[1] <= within_box(c1_reg[0], c1_reg[1], c1_reg[6], c1_reg[7],
                                     c1_reg[2], c1_reg[3]);
            box_reg[2] <= within_box(c1_reg[4], c1_reg[5], c1_reg[0], c1_reg[1],
                                     c1_reg[6], c1_reg[7]);
            box_reg[3] <= within_box(c1_reg[4], c1_reg[5], c1_reg[2], c1_reg[3],
                                     c1_reg[6], c1_reg[7]);
            dax2_reg <= dax_reg;
            day2_reg <= day_reg;
            p1x2_reg <= c1_reg[0];
            p1y2_reg <= c1_reg[1];
        end
    end

    // Stage 3: cross values, hit decision and unsigned divider operands.
    logic signed [WD-1:0] cv [6];
    orient_t              o1, o2, o3, o4;
    logic                 hit_c;
    logic [WD-1:0]        dd_c, n_c;
    pipe_ctl_t            ctl_next;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            cv[k] = WD'(pr_reg[2*k]) - WD'(pr_reg[2*k+1]);
        end
        o1 = orient_of(cv[0]);
        o2 = orient_of(cv[1]);
        o3 = orient_of(cv[2]);
        o4 = orient_of(cv[3]);
        hit_c = ((o1 != o2) && (o3 != o4))
             || ((o1 == ORIENT_COLLINEAR) && box_reg[0])
             || ((o2 == ORIENT_COLLINEAR) && box_reg[1])
             || ((o3 == ORIENT_COLLINEAR) && box_reg[2])
             || ((o4 == ORIENT_COLLINEAR) && box_reg[3]);
        dd_c = cv[4][WD-1] ? -cv[4] : cv[4];
        n_c  = cv[5][WD-1] ? -cv[5] : cv[5];
        if (n_c > dd_c) begin
            n_c = dd_c;
        end
        ctl_next.valid = v2_reg;
        ctl_next.hit   = hit_c;
        ctl_next.par   = (cv[4] == '0);
        ctl_next.neg_x = cv[5][WD-1] ^ cv[4][WD-1] ^ dax2_reg[W1-1];
        ctl_next.neg_y = cv[5][WD-1] ^ cv[4][WD-1] ^ day2_reg[W1-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl <= '0;
        end else if (en) begin
            ctl <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dd    <= dd_c;
            num   <= n_c;
            mag_x <= dax2_reg[W1-1] ? W1'(-dax2_reg) : W1'(dax2_reg);
            mag_y <= day2_reg[W1-1] ? W1'(-day2_reg) : W1'(day2_reg);
            p1x_o <= p1x2_reg;
            p1y_o <= p1y2_reg;
        end
    end

endmodule

### rtl/sip_div_stage.sv
// One quotient bit of the scaled division, for both axes.
module sip_div_stage
    import sip_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int BIT        = 0
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  pipe_ctl_t                    ctl_i,
    input  logic [2*COORD_BITS+2:0]      dd_i,
    input  logic [2*COORD_BITS+2:0]      num_i,
    input  logic [COORD_BITS:0]          mag_x_i,
    input  logic [COORD_BITS:0]          mag_y_i,
    input  logic [2*COORD_BITS+4:0]      rem_x_i,
    input  logic [2*COORD_BITS+4:0]      rem_y_i,
    input  logic [COORD_BITS:0]          quo_x_i,
    input  logic [COORD_BITS:0]          quo_y_i,
    input  logic signed [COORD_BITS-1:0] p1x_i,
    input  logic signed [COORD_BITS-1:0] p1y_i,
    output pipe_ctl_t                    ctl_o,
    output logic [2*COORD_BITS+2:0]      dd_o,
    output logic [2*COORD_BITS+2:0]      num_o,
    output logic [COORD_BITS:0]          mag_x_o,
    output logic [COORD_BITS:0]          mag_y_o,
    output logic [2*COORD_BITS+4:0]      rem_x_o,
    output logic [2*COORD_BITS+4:0]      rem_y_o,
    output logic [COORD_BITS:0]          quo_x_o,
    output logic [COORD_BITS:0]          quo_y_o,
    output logic signed [COORD_BITS-1:0] p1x_o,
    output logic signed [COORD_BITS-1:0] p1y_o
);
    localparam int W1 = COORD_BITS + 1;
    localparam int WD = 2 * COORD_BITS + 3;
    localparam int WR = WD + 2;

    // Double the remainder, reduce, then add the numerator if this bit of
    // the multiplier is set and reduce again.
    function automatic logic [WR+W1-1:0] step(input logic [WR-1:0] r, input logic [W1-1:0] q,
                                              input logic mbit);
        logic [WR-1:0] rr;
        logic [W1-1:0] qq;
        rr = r << 1;
        qq = q << 1;
        if (rr >= WR'(dd_i)) begin
            qq = qq + 1'b1;
            rr = rr - WR'(dd_i);
        end
        if (mbit) begin
            rr = rr + WR'(num_i);
            if (rr >= WR'(dd_i)) begin
                qq = qq + 1'b1;
                rr = rr - WR'(dd_i);
            end
        end
        return {rr, qq};
    endfunction

    logic [WR+W1-1:0] sx_c, sy_c;
    assign sx_c = step(rem_x_i, quo_x_i, mag_x_i[BIT]);
    assign sy_c = step(rem_y_i, quo_y_i, mag_y_i[BIT]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_o <= '0;
        end else if (en) begin
            ctl_o <= ctl_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dd_o    <= dd_i;
            num_o   <= num_i;
            mag_x_o <= mag_x_i;
            mag_y_o <= mag_y_i;
            rem_x_o <= sx_c[WR+W1-1:W1];
            quo_x_o <= sx_c[W1-1:0];
            rem_y_o <= sy_c[WR+W1-1:W1];
            quo_y_o <= sy_c[W1-1:0];
            p1x_o   <= p1x_i;
            p1y_o   <= p1y_i;
        end
    end

endmodule

### rtl/segment_intersection_point.sv
// Top level of the pipelined segment intersection and crossing point unit.
//
//  Channel   Direction  Word contents (lowest bit first)
//  s_axis    in         a_start_x a_start_y a_end_x a_end_y b_start_x b_start_y b_end_x b_end_y
//  m_axis    out        hit parallel cross_x cross_y, zero padded to bytes
//
// One word is accepted every cycle unless an output word waits with m_tready low. Stages:
// three front stages, one divider stage per multiplier bit (COORD_BITS + 1), one output stage.
// The per-bit shift-and-subtract divider chain sets the latency.
// aresetn is synchronous and active low and clears only the valid and control bits.
// The whole pipeline advances together: it holds when the output word is waiting
// and m_tready is low, so a stall drops and repeats nothing.
`include "segment_intersection_point_defines.svh"

module segment_intersection_point
    import sip_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
    input  logic [8*COORD_BITS-1:0]  s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // hit, parallel, cross_x, cross_y, then zero padding
    output logic [((2*COORD_BITS+2+7)/8)*8-1:0] m_tdata
);
    localparam int C   = COORD_BITS;
    localparam int W1  = C + 1;
    localparam int WD  = 2 * C + 3;
    localparam int WR  = WD + 2;
    localparam int NST = C + 1;
    localparam int OW  = ((2 * C + 2 + 7) / 8) * 8;

    // The pipeline moves whenever the output register is empty or being drained.
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    pipe_ctl_t           ctl_a   [NST+1];
    logic [WD-1:0]       dd_a    [NST+1];
    logic [WD-1:0]       num_a   [NST+1];
    logic [W1-1:0]       mx_a    [NST+1];
    logic [W1-1:0]       my_a    [NST+1];
    logic [WR-1:0]       rx_a    [NST+1];
    logic [WR-1:0]       ry_a    [NST+1];
    logic [W1-1:0]       qx_a    [NST+1];
    logic [W1-1:0]       qy_a    [NST+1];
    logic signed [C-1:0] px_a    [NST+1];
    logic signed [C-1:0] py_a    [NST+1];

    sip_front #(.COORD_BITS(C)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .in_data  (s_tdata),
        .ctl      (ctl_a[0]),
        .dd       (dd_a[0]),
        .num      (num_a[0]),
        .mag_x    (mx_a[0]),
        .mag_y    (my_a[0]),
        .p1x_o    (px_a[0]),
        .p1y_o    (py_a[0])
    );

    // The divider starts from a zero remainder and quotient.
    assign rx_a[0] = '0;
    assign ry_a[0] = '0;
    assign qx_a[0] = '0;
    assign qy_a[0] = '0;

    // Stage k resolves multiplier bit C - k, most significant first.
    for (genvar k = 0; k < NST; k++) begin : g_div
        sip_div_stage #(.COORD_BITS(C), .BIT(C - k)) u_stage (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctl_i   (ctl_a[k]),   .ctl_o   (ctl_a[k+1]),
            .dd_i    (dd_a[k]),    .dd_o    (dd_a[k+1]),
            .num_i   (num_a[k]),   .num_o   (num_a[k+1]),
            .mag_x_i (mx_a[k]),    .mag_x_o (mx_a[k+1]),
            .mag_y_i (my_a[k]),    .mag_y_o (my_a[k+1]),
            .rem_x_i (rx_a[k]),    .rem_x_o (rx_a[k+1]),
            .rem_y_i (ry_a[k]),    .rem_y_o (ry_a[k+1]),
            .quo_x_i (qx_a[k]),    .quo_x_o (qx_a[k+1]),
            .quo_y_i (qy_a[k]),    .quo_y_o (qy_a[k+1]),
            .p1x_i   (px_a[k]),    .p1x_o   (px_a[k+1]),
            .p1y_i   (py_a[k]),    .p1y_o   (py_a[k+1])
        );
    end

    // Output stage: apply the sign, add A's start, and force zero unless the
    // segments hit without being parallel.
    pipe_ctl_t         fin;
    logic [C+1:0]      qsx, qsy, sumx, sumy;
    logic              take_point;
    logic [OW-1:0]     m_tdata_next;
    logic              m_tvalid_reg;
    logic [OW-1:0]     m_tdata_reg;

    always_comb begin
        fin  = ctl_a[NST];
        qsx  = fin.neg_x ? ((C+2)'(0) - {1'b0, qx_a[NST]}) : {1'b0, qx_a[NST]};
        qsy  = fin.neg_y ? ((C+2)'(0) - {1'b0, qy_a[NST]}) : {1'b0, qy_a[NST]};
        sumx = {{2{px_a[NST][C-1]}}, px_a[NST]} + qsx;
        sumy = {{2{py_a[NST][C-1]}}, py_a[NST]} + qsy;
        take_point = fin.hit && !fin.par;
        m_tdata_next = '0;
        m_tdata_next[0] = fin.hit;
        m_tdata_next[1] = fin.par;
        if (take_point) begin
            m_tdata_next[2 +: C]     = sumx[C-1:0];
            m_tdata_next[2 + C +: C] = sumy[C-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= fin.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A word that waits on the output must still be there next cycle.
    `SIP_ASSERT_NEXT(a_out_held, m_tvalid && !m_tready, m_tvalid)
    // No crossing point unless the segments hit and are not parallel.
    `SIP_ASSERT_NOW(a_point_zero, m_tvalid && (!m_tdata[0] || m_tdata[1]), m_tdata[2 +: 2*C] == '0)
    // A stall freezes the front end control.
    `SIP_ASSERT_NEXT(a_front_hold, !en, $stable(ctl_a[0]))

endmodule

### dv/tb_top.sv
// Self-checking testbench for the pipelined segment intersection and crossing point unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = 16;
    localparam int OW = ((2*CB+2+7)/8)*8;
    localparam int PIPE_DEPTH = CB + 5;

    typedef struct packed {
        logic signed [CB-1:0] bey, bex, bsy, bsx, aey, aex, asy, asx;
    } seg_pair_t;

    typedef struct packed {
        logic       hit;
        logic       par;
        logic [15:0] cx;
        logic [15:0] cy;
    } isect_t;

    typedef enum int {
        IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH
    } idle_mode_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [8*CB-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OW-1:0] m_tdata;

    seg_pair_t pending_pairs[$];
    isect_t    expected_isect[$];
    idle_mode_t idle_mode = IDLE_NONE;
    int  error_count = 0;
    bit  stim_done = 1'b0;
    // Set at the rising edge that accepted an input word.
    bit  in_taken = 1'b0;

    always #2 aclk = ~aclk;

    segment_intersection_point #(.COORD_BITS(CB)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Appends one word to the pending input queue.
    task automatic enqueue_pair(input seg_pair_t w);
        pending_pairs = {pending_pairs, w};
    endtask

    // Orientation of r relative to the directed line p->q: 0 collinear, 1 pos, 2 neg.
    function automatic int orient_of(longint px, longint py, longint qx, longint qy,
                                     longint rx, longint ry);
        longint v;
        v = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
        if (v == 0) return 0;
        return (v > 0) ? 1 : 2;
    endfunction

    function automatic bit in_box(longint px, longint py, longint qx, longint qy,
                                  longint rx, longint ry);
        longint xlo, xhi, ylo, yhi;
        xlo = (px < rx) ? px : rx;
        xhi = (px < rx) ? rx : px;
        ylo = (py < ry) ? py : ry;
        yhi = (py < ry) ? ry : py;
        return qx >= xlo && qx <= xhi && qy >= ylo && qy <= yhi;
    endfunction

    // Computes the expected hit, parallel and crossing point for one segment pair.
    function automatic isect_t intersect_pair(seg_pair_t w);
        longint p1x, p1y, q1x, q1y, p2x, p2y, q2x, q2y;
        longint dax, day, dbx, dby, den, tn, ox, oy;
        int o1, o2, o3, o4;
        bit hit;
        isect_t r;
        p1x = w.asx; p1y = w.asy; q1x = w.aex; q1y = w.aey;
        p2x = w.bsx; p2y = w.bsy; q2x = w.bex; q2y = w.bey;
        o1 = orient_of(p1x, p1y, q1x, q1y, p2x, p2y);
        o2 = orient_of(p1x, p1y, q1x, q1y, q2x, q2y);
        o3 = orient_of(p2x, p2y, q2x, q2y, p1x, p1y);
        o4 = orient_of(p2x, p2y, q2x, q2y, q1x, q1y);
        hit = (o1 != o2 && o3 != o4)
            || (o1 == 0 && in_box(p1x, p1y, p2x, p2y, q1x, q1y))
            || (o2 == 0 && in_box(p1x, p1y, q2x, q2y, q1x, q1y))
            || (o3 == 0 && in_box(p2x, p2y, p1x, p1y, q2x, q2y))
            || (o4 == 0 && in_box(p2x, p2y, q1x, q1y, q2x, q2y));
        dax = q1x - p1x; day = q1y - p1y;
        dbx = q2x - p2x; dby = q2y - p2y;
        den = dax * dby - dbx * day;
        ox = 0; oy = 0;
        if (hit && den != 0) begin
            tn = dbx * (p1y - p2y) - dby * (p1x - p2x);
            // SystemVerilog division truncates toward zero; products fit in 64 bits.
            ox = p1x + (tn * dax) / den;
            oy = p1y + (tn * day) / den;
        end
        r.hit = hit;
        r.par = (den == 0);
        r.cx = ox[15:0];
        r.cy = oy[15:0];
        return r;
    endfunction

    function automatic logic [CB-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return CB'($urandom_range(0, 15)) - 16'd8;
            default: return CB'($urandom);
        endcase
    endfunction

    function automatic seg_pair_t rand_pair();
        seg_pair_t w;
        int k;
        logic signed [CB-1:0] mx, my;
        w = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        k = $urandom_range(0, 9);
        if (k < 5) begin
            // Force B through a point on A so that hits are common.
            mx = CB'((longint'(w.asx) + longint'(w.aex)) >>> 1);
            my = CB'((longint'(w.asy) + longint'(w.aey)) >>> 1);
            w.bex = CB'(2 * longint'(mx) - longint'(w.bsx));
            w.bey = CB'(2 * longint'(my) - longint'(w.bsy));
            if (k == 0) begin
                w.bsx = w.asx; w.bsy = w.asy;
            end
        end else if (k == 5) begin
            // Collinear with A, starting at A's end and extending away from it.
            w.bsx = w.aex; w.bsy = w.aey;
            w.bex = CB'(2 * longint'(w.aex) - longint'(w.asx));
            w.bey = CB'(2 * longint'(w.aey) - longint'(w.asy));
        end else if (k == 6) begin
            w.aex = w.asx; w.aey = w.asy;
        end
        return w;
    endfunction

    // Driver: presents pending words, changes inputs on the falling edge.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_taken) begin
                void'(pending_pairs.pop_front());
            end
            if (!s_tvalid || in_taken) begin
                if (pending_pairs.size() > 0 &&
                    !((idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) &&
                      $urandom_range(0, 99) < ((idle_mode == IDLE_SEND) ? 75 : 6))) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_pairs[0];
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= !((idle_mode == IDLE_RECV || idle_mode == IDLE_BOTH) &&
                          $urandom_range(0, 99) < ((idle_mode == IDLE_RECV) ? 75 : 6));
        end
    end

    // Records the expectation for each accepted input word.
    always @(posedge aclk) begin
        in_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            expected_isect.insert(expected_isect.size(), intersect_pair(s_tdata));
        end
    end

    // Monitor: checks each accepted output word against the oldest expectation.
    always @(posedge aclk) begin
        isect_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.hit = m_tdata[0];
            got.par = m_tdata[1];
            got.cx  = m_tdata[2 +: 16];
            got.cy  = m_tdata[18 +: 16];
            if (expected_isect.size() == 0) begin
                $error("output word with no expectation: %h", m_tdata);
                error_count++;
            end else begin
                want = expected_isect.pop_front();
                if (got.hit !== want.hit) begin
                    $error("hit: expected %0d actual %0d", want.hit, got.hit);
                    error_count++;
                end
                if (got.par !== want.par) begin
                    $error("parallel: expected %0d actual %0d", want.par, got.par);
                    error_count++;
                end
                if (got.cx !== want.cx) begin
                    $error("cross_x: expected %0d actual %0d",
                           $signed(want.cx), $signed(got.cx));
                    error_count++;
                end
                if (got.cy !== want.cy) begin
                    $error("cross_y: expected %0d actual %0d",
                           $signed(want.cy), $signed(got.cy));
                    error_count++;
                end
            end
        end
    end

    initial begin
        seg_pair_t w;
        int ph, i;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        // Directed words: extremes, a plain crossing, touching ends, collinear
        // overlap, collinear gap, parallel apart, and zero-length segments.
        enqueue_pair('{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000,
                       16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000});
        enqueue_pair('{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
                       16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff});
        enqueue_pair('{-16'sd10, 16'sd10, 16'sd10, -16'sd10,
                       16'sd10, 16'sd10, -16'sd10, -16'sd10});
        enqueue_pair('{16'sd3, 16'sd7, 16'sd1, 16'sd0,
                       16'sd3, 16'sd5, 16'sd0, 16'sd0});
        enqueue_pair('{16'sd9, 16'sd9, 16'sd5, 16'sd5,
                       16'sd0, 16'sd0, 16'sd0, 16'sd0});
        enqueue_pair('{16'sd0, 16'sd9, 16'sd0, 16'sd5,
                       16'sd0, 16'sd4, 16'sd0, 16'sd0});
        enqueue_pair('{16'sd5, 16'sd9, 16'sd1, 16'sd0,
                       16'sd4, 16'sd9, 16'sd0, 16'sd0});
        enqueue_pair('{16'sd2, 16'sd2, 16'sd2, 16'sd2,
                       16'sd4, 16'sd4, 16'sd0, 16'sd0});
        enqueue_pair('{16'sd3, 16'sd3, 16'sd3, 16'sd3,
                       16'sd3, 16'sd3, 16'sd3, 16'sd3});
        enqueue_pair('{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
                       16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff});
        enqueue_pair('{-16'sd7, 16'sd3, 16'sd2, -16'sd5,
                       16'sd1, 16'sd6, -16'sd3, -16'sd4});
        for (ph = 0; ph < 4; ph++) begin
            idle_mode = idle_mode_t'(ph);
            for (i = 0; i < 450; i++) begin
                w = rand_pair();
                enqueue_pair(w);
            end
            while (pending_pairs.size() != 0 || s_tvalid) @(posedge aclk);
        end
        while (expected_isect.size() != 0) @(posedge aclk);
        repeat (2 * PIPE_DEPTH) @(posedge aclk);
        if (error_count == 0 && expected_isect.size() == 0) begin
            $display("segment_intersection_point regression: pass");
        end else begin
            $display("segment_intersection_point regression: fail");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("segment_intersection_point regression: fail");
        $finish;
    end
endmodule
